[sv/dbad_pkg.sv]
// ----------------------------------------------------------------------------
// dbad_pkg
// shared widths, limits and seven-segment codes for the button adder display
// ----------------------------------------------------------------------------
package dbad_pkg;

   localparam int SUM_W      = 10;           // running sum width
   localparam int SUM_WIDE_W = SUM_W + 1;    // sum plus one beat of presses
   localparam int SEG_W      = 8;            // one seven-segment code
   localparam int LEVELS_W   = 8;            // raw button pins per beat
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = 4 * DIGIT_W;

   localparam logic [SUM_WIDE_W-1:0] SUM_LIMIT = SUM_WIDE_W'(1023);
   localparam logic [SEG_W-1:0]      SEG_BLANK = 8'hFF;

   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [SEG_W-1:0]   seg_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      seg_type ones;
      seg_type tens;
      seg_type hundreds;
      seg_type thousands;
   } seg_codes_type;

   // active-low common-anode codes, segment a at bit 0
   function automatic seg_type seg_code(input digit_type digit);
      seg_type code;
      unique case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

[sv/debounced_button_adder_display.sv]
// ----------------------------------------------------------------------------
// debounced_button_adder_display
// debounced eight-button weighted adder with four-digit seven-segment readout
// ----------------------------------------------------------------------------
//  channel | ports                 | payload
//  --------+-----------------------+------------------------------------------
//  req     | req_valid / req_stall | req_button_levels (active-low pins)
//  rsp     | rsp_valid / rsp_stall | rsp_sum_value, rsp_*_code (seg codes)
//
//  one beat per cycle while rsp_stall is low; a beat passes stage a, then b
//  stage a: debouncers and running sum update on the accepted beat
//  stage b: decimal split and segment coding into the result register
//  synchronous active-high reset clears histories, sum and both valid bits
//  rsp_stall backs up stage b, then stage a, then raises req_stall
// ----------------------------------------------------------------------------
module debounced_button_adder_display
   import dbad_pkg::*;
#(
   parameter int NUM_BUTTONS    = 8,
   parameter int STABLE_SAMPLES = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LEVELS_W-1:0] req_button_levels,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sum_type             rsp_sum_value,
   output seg_type             rsp_ones_code,
   output seg_type             rsp_tens_code,
   output seg_type             rsp_hundreds_code,
   output seg_type             rsp_thousands_code
);

   // handshake control
   logic accept;
   logic a_ready;
   logic b_ready;

   // stage a
   logic                   a_valid_ff;
   logic                   a_valid_in;
   sum_type                a_sum_ff;
   sum_type                running_sum_ff;
   sum_type                running_sum_in;
   logic [NUM_BUTTONS-1:0] press;
   logic [SUM_WIDE_W-1:0]  sum_wide;

   // stage b / result register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sum_type       rsp_sum_ff;
   seg_codes_type rsp_codes_ff;
   seg_codes_type codes;

   assign b_ready   = !rsp_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   // one debouncer per button, pins from NUM_BUTTONS up are unused
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      dbad_debounce #(
         .STABLE_SAMPLES(STABLE_SAMPLES)
      ) u_debounce (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .level    (req_button_levels[i]),
         .press    (press[i])
      );
   end

   // press of button i weighs 2^i, so the press vector is the addend itself
   assign sum_wide = SUM_WIDE_W'(running_sum_ff) + SUM_WIDE_W'(press);

   // bound: at most 1278, one subtract of the limit brings it back in range
   always_comb begin
      if (sum_wide > SUM_LIMIT) begin
         running_sum_in = SUM_W'(sum_wide - SUM_LIMIT);
      end else begin
         running_sum_in = SUM_W'(sum_wide);
      end
   end

   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (b_ready) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   assign rsp_valid_in = b_ready ? a_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         running_sum_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) begin
            running_sum_ff <= running_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sum_ff <= running_sum_in;
      end
   end

   // decimal digits and segment codes of the stage a sum
   dbad_seg_encode u_seg_encode (
      .sum_value (a_sum_ff),
      .codes     (codes)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only when the result register frees up
   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         rsp_sum_ff   <= a_sum_ff;
         rsp_codes_ff <= codes;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum_value      = rsp_sum_ff;
   assign rsp_ones_code      = rsp_codes_ff.ones;
   assign rsp_tens_code      = rsp_codes_ff.tens;
   assign rsp_hundreds_code  = rsp_codes_ff.hundreds;
   assign rsp_thousands_code = rsp_codes_ff.thousands;

endmodule

[sv/dbad_debounce.sv]
// ----------------------------------------------------------------------------
// dbad_debounce
// per-button sample history with single-shot press detection
// ----------------------------------------------------------------------------
module dbad_debounce #(
   parameter int STABLE_SAMPLES = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic level,
   output logic press
);

   localparam int HistW = STABLE_SAMPLES + 1;

   logic [HistW-1:0] hist_ff;
   logic [HistW-1:0] hist_in;

   // low run of STABLE_SAMPLES samples right after a released sample
   assign hist_in = {hist_ff[HistW-2:0], level};
   assign press   = shift_en && hist_in[HistW-1] && (hist_in[HistW-2:0] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (shift_en) begin
         hist_ff <= hist_in;
      end
   end

endmodule

[sv/dbad_seg_encode.sv]
// ----------------------------------------------------------------------------
// dbad_seg_encode
// binary to decimal split and seven-segment coding with leading-zero blanking
// ----------------------------------------------------------------------------
module dbad_seg_encode
   import dbad_pkg::*;
(
   input  sum_type       sum_value,
   output seg_codes_type codes
);

   logic [BCD_W-1:0] bcd;
   digit_type        d_ones;
   digit_type        d_tens;
   digit_type        d_hundreds;
   digit_type        d_thousands;

   // shift-add-3 over the ten sum bits
   always_comb begin
      logic [BCD_W-1:0] acc;
      acc = '0;
      for (int i = SUM_W - 1; i >= 0; i--) begin
         for (int d = 0; d < 4; d++) begin
            if (acc[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         acc = {acc[BCD_W-2:0], sum_value[i]};
      end
      bcd = acc;
   end

   assign d_ones      = bcd[3:0];
   assign d_tens      = bcd[7:4];
   assign d_hundreds  = bcd[11:8];
   assign d_thousands = bcd[15:12];

   always_comb begin
      codes.ones      = seg_code(d_ones);
      codes.tens      = (d_thousands == '0 && d_hundreds == '0 && d_tens == '0)
                        ? SEG_BLANK : seg_code(d_tens);
      codes.hundreds  = (d_thousands == '0 && d_hundreds == '0)
                        ? SEG_BLANK : seg_code(d_hundreds);
      codes.thousands = (d_thousands == '0) ? SEG_BLANK : seg_code(d_thousands);
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the debounced button adder display: a table of
// directed scan ticks, then random press and bounce sequences, with random
// idle and stall on both sides and one long result hold-off
// ----------------------------------------------------------------------------
module tb
   import dbad_pkg::*;
();

   localparam int NUM_BTN      = 8;
   localparam int HIST_W       = 13;      // stable window plus the edge sample
   localparam int RANDOM_BEATS = 290;
   localparam int LONG_HOLD    = 80;      // cycles the receiver sits on its stall
   localparam int HOLD_AT      = 150;     // result count that triggers the hold
   localparam int LIMIT_CYCLES = 60000;   // ~450 beats with their gaps and stalls
   localparam int MAX_REPORTS  = 10;

   // active-low common-anode digit codes, segment a at bit 0
   localparam seg_type DIGIT_SEG [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   typedef struct packed {
      sum_type sum;
      seg_type ones;
      seg_type tens;
      seg_type hundreds;
      seg_type thousands;
   } readout_type;

   // one table row is a level pattern held for a number of scan ticks;
   // a typed row gives the readout expected on its last tick
   typedef struct packed {
      logic [LEVELS_W-1:0] levels;
      logic [7:0]          beats;
      logic                typed;
      readout_type         want;
   } scan_row_type;

   localparam readout_type SHOW_0 =
      '{10'd0, DIGIT_SEG[0], SEG_BLANK, SEG_BLANK, SEG_BLANK};
   localparam readout_type SHOW_255 =
      '{10'd255, DIGIT_SEG[5], DIGIT_SEG[5], DIGIT_SEG[2], SEG_BLANK};
   localparam readout_type SHOW_1023 =
      '{10'd1023, DIGIT_SEG[3], DIGIT_SEG[2], DIGIT_SEG[0], DIGIT_SEG[1]};
   localparam readout_type NO_READOUT = '0;

   localparam int NUM_ROWS = 22;
   localparam scan_row_type SCAN_ROWS [NUM_ROWS] = '{
      '{8'h00, 8'd14, 1'b1, SHOW_0},       // held from reset: never counted
      '{8'hFF, 8'd1,  1'b1, SHOW_0},       // release
      '{8'h00, 8'd12, 1'b1, SHOW_255},     // all eight pressed, full window
      '{8'h00, 8'd20, 1'b1, SHOW_255},     // still held: no second count
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h00, 8'd12, 1'b0, NO_READOUT},   // 510
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h00, 8'd12, 1'b0, NO_READOUT},   // 765
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h00, 8'd12, 1'b0, NO_READOUT},   // 1020
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'hFC, 8'd12, 1'b1, SHOW_1023},    // buttons 0 and 1: top of range
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h00, 8'd12, 1'b1, SHOW_255},     // largest overflow, wraps down
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h00, 8'd5,  1'b0, NO_READOUT},   // bounce: too short to count
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'hAA, 8'd12, 1'b0, NO_READOUT},   // even buttons
      '{8'hFF, 8'd1,  1'b0, NO_READOUT},
      '{8'h7F, 8'd12, 1'b0, NO_READOUT},   // top button alone
      '{8'hFF, 8'd3,  1'b0, NO_READOUT},
      '{8'hFE, 8'd12, 1'b0, NO_READOUT}    // bottom button alone
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [LEVELS_W-1:0] req_button_levels = '1;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sum_type             rsp_sum_value;
   seg_type             rsp_ones_code;
   seg_type             rsp_tens_code;
   seg_type             rsp_hundreds_code;
   seg_type             rsp_thousands_code;

   // predictor state: per-button sample history and the running sum
   logic [HIST_W-1:0] sample_hist [NUM_BTN];
   sum_type           sum_now;

   readout_type pending_readouts [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          readouts_seen = 0;
   int          stall_left = 0;
   bit          sender_busy = 1'b0;   // sender offers back to back when set

   always #4 clock = ~clock;

   debounced_button_adder_display dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_button_levels  (req_button_levels),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sum_value      (rsp_sum_value),
      .rsp_ones_code      (rsp_ones_code),
      .rsp_tens_code      (rsp_tens_code),
      .rsp_hundreds_code  (rsp_hundreds_code),
      .rsp_thousands_code (rsp_thousands_code)
   );

   // one scan tick: shift every button, count fresh presses, bound the sum
   function automatic readout_type scan_tick(input logic [LEVELS_W-1:0] levels);
      logic [HIST_W-1:0] hist;
      logic [SUM_W:0]    acc;
      readout_type       show;
      acc = {1'b0, sum_now};
      for (int b = 0; b < NUM_BTN; b++) begin
         hist = {sample_hist[b][HIST_W-2:0], levels[b]};
         sample_hist[b] = hist;
         // low for the whole window, high on the sample just before it
         if (hist[HIST_W-2:0] == '0 && hist[HIST_W-1])
            acc += (SUM_W+1)'(1) << b;
      end
      if (acc > (SUM_W+1)'(1023))
         acc -= (SUM_W+1)'(1023);
      sum_now = acc[SUM_W-1:0];
      show.sum       = sum_now;
      show.ones      = DIGIT_SEG[sum_now % 10];
      show.tens      = (sum_now < 10)   ? SEG_BLANK : DIGIT_SEG[(sum_now / 10) % 10];
      show.hundreds  = (sum_now < 100)  ? SEG_BLANK : DIGIT_SEG[(sum_now / 100) % 10];
      show.thousands = (sum_now < 1000) ? SEG_BLANK : DIGIT_SEG[(sum_now / 1000) % 10];
      return show;
   endfunction

   // offer one beat, after a random gap unless sender_busy, and wait for it
   // to be taken, then queue the readout it should produce
   task automatic offer_scan(input logic [LEVELS_W-1:0] levels, input logic typed,
                             input readout_type want);
      int          gap;
      readout_type predicted;
      gap = sender_busy ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      do @(posedge clock); while (req_stall);
      predicted = scan_tick(levels);
      pending_readouts.push_back(typed ? want : predicted);
   endtask

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d readouts outstanding",
                  cycle_count, pending_readouts.size());
         $display("** debounced_button_adder_display: FAILED **");
         $finish;
      end
   end

   // receiver: check each taken beat against the oldest expectation, then
   // draw a stall for the next one; once, sit on a long stall so the block
   // backs up into req_stall while the sender keeps offering
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         readouts_seen++;
         if (pending_readouts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected readout: sum %0d", rsp_sum_value);
         end else begin
            readout_type want;
            want = pending_readouts.pop_front();
            if (rsp_sum_value != want.sum || rsp_ones_code != want.ones
                || rsp_tens_code != want.tens || rsp_hundreds_code != want.hundreds
                || rsp_thousands_code != want.thousands) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("readout %0d: expected %0d %h %h %h %h, got %0d %h %h %h %h",
                           readouts_seen, want.sum, want.ones, want.tens,
                           want.hundreds, want.thousands, rsp_sum_value,
                           rsp_ones_code, rsp_tens_code, rsp_hundreds_code,
                           rsp_thousands_code);
            end
         end
         // every fifth window of results draws no random stall
         stall_left = ((readouts_seen / 37) % 5 == 4) ? 0 : $urandom_range(0, 4);
         if (readouts_seen == HOLD_AT)
            stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stimulus: reset, the directed table, then random press sequences
   initial begin
      logic [LEVELS_W-1:0] levels;
      logic                run_level [NUM_BTN];
      int                  run_left  [NUM_BTN];
      int                  beat_no;

      for (int b = 0; b < NUM_BTN; b++) begin
         sample_hist[b] = '0;
         run_level[b]   = 1'b1;
         run_left[b]    = 0;
      end
      sum_now = '0;
      beat_no = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: typed rows check their last tick against the table
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int k = 0; k < SCAN_ROWS[r].beats; k++) begin
            sender_busy = ((beat_no / 40) % 5 == 3);
            offer_scan(SCAN_ROWS[r].levels,
                       SCAN_ROWS[r].typed && (k == SCAN_ROWS[r].beats - 1),
                       SCAN_ROWS[r].want);
            beat_no++;
         end
      end

      // random part: each button alternates released runs with pressed runs,
      // mostly long enough to count, sometimes short bounces; a few ticks
      // are pure noise on all pins
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         for (int b = 0; b < NUM_BTN; b++) begin
            if (run_left[b] == 0) begin
               run_level[b] = ~run_level[b];
               if (!run_level[b])
                  run_left[b] = ($urandom_range(0, 9) < 7) ? $urandom_range(12, 16)
                                                           : $urandom_range(1, 11);
               else
                  run_left[b] = $urandom_range(1, 5);
            end
            levels[b] = run_level[b];
            run_left[b]--;
         end
         if ($urandom_range(0, 99) < 8)
            levels = LEVELS_W'($urandom);
         sender_busy = ((beat_no / 40) % 5 == 3);
         offer_scan(levels, 1'b0, NO_READOUT);
         beat_no++;
      end
      req_valid <= 1'b0;

      // drain, then give the two-stage pipe time to show any stray beat
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("** debounced_button_adder_display: PASSED **");
      end else begin
         $display("%0d mismatching readouts", mismatches);
         $display("** debounced_button_adder_display: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/dbad_pkg.sv
sv/dbad_debounce.sv
sv/dbad_seg_encode.sv
sv/debounced_button_adder_display.sv
dv/tb.sv
